[rtl/xor_checked_frame_parser_macros.svh]
// Assertion macros used by the frame parser port checker.
`ifndef XOR_CHECKED_FRAME_PARSER_MACROS_SVH
`define XOR_CHECKED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define XCFP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define XCFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

[rtl/xcfp_pkg.sv]
// Shared types, codes and constants of the frame parser.
package xcfp_pkg;

  localparam int XCFP_MAX_PAYLOAD = 64;
  localparam logic [7:0] XCFP_MAGIC_RESET = 8'hAA;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_FRAME = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_CMD   = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DEC_NONE  = 2'd0,
    DEC_ERROR = 2'd1,
    DEC_EMPTY = 2'd2,
    DEC_BURST = 2'd3
  } dec_kind_t;

  typedef struct packed {
    dec_kind_t   kind;
    logic [7:0]  cmd;
    logic [6:0]  len;
  } parse_dec_t;

endpackage

[rtl/xcfp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module xcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/xcfp_parser.sv]
// Frame phase tracker: running checksum, payload writes, per-beat decision.
module xcfp_parser import xcfp_pkg::*; #(
  parameter int MAX_PAYLOAD = XCFP_MAX_PAYLOAD,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    magic,
  output parse_dec_t    dec,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [6:0] len_r, len_nxt;
  logic [6:0] fill_r, fill_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       is_magic;
  logic       len_bad;
  logic [6:0] fill_inc;

  assign is_magic = (rx_byte == magic);
  assign len_bad  = (rx_byte > 8'(MAX_PAYLOAD));
  assign fill_inc = fill_r + 7'd1;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (is_magic) begin
      phase_nxt = PH_CMD;
    end else begin
      unique case (phase_r)
        PH_WAIT:  phase_nxt = PH_WAIT;
        PH_CMD:   phase_nxt = PH_LEN;
        PH_LEN: begin
          if (len_bad) begin
            phase_nxt = PH_WAIT;
          end else if (rx_byte == 8'd0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA:  phase_nxt = (fill_inc >= len_r) ? PH_CHECK : PH_DATA;
        PH_CHECK: phase_nxt = PH_WAIT;
        default:  phase_nxt = PH_WAIT;
      endcase
    end
  end

  // Held fields, store writes and the decision for this beat.
  always_comb begin
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    wr_en     = 1'b0;
    wr_addr   = fill_r[AW-1:0];
    wr_data   = rx_byte;
    dec.kind  = DEC_NONE;
    dec.cmd   = cmd_r;
    dec.len   = len_r;
    if (is_magic) begin
      fill_nxt = 7'd0;
    end else begin
      unique case (phase_r)
        PH_WAIT: ;
        PH_CMD: begin
          cmd_nxt = rx_byte;
          sum_nxt = rx_byte;
        end
        PH_LEN: begin
          if (len_bad) begin
            dec.kind = DEC_ERROR;
          end else begin
            len_nxt  = rx_byte[6:0];
            fill_nxt = 7'd0;
            sum_nxt  = sum_r ^ rx_byte;
          end
        end
        PH_DATA: begin
          wr_en    = acc;
          fill_nxt = fill_inc;
          sum_nxt  = sum_r ^ rx_byte;
        end
        PH_CHECK: begin
          fill_nxt = 7'd0;
          if (sum_r != rx_byte) begin
            dec.kind = DEC_ERROR;
          end else if (len_r == 7'd0) begin
            dec.kind = DEC_EMPTY;
          end else begin
            dec.kind = DEC_BURST;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cmd_r   <= 8'd0;
      len_r   <= 7'd0;
      fill_r  <= 7'd0;
      sum_r   <= 8'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

[rtl/xcfp_emitter.sv]
// Result register and payload burst sequencer reading the payload RAM.
module xcfp_emitter import xcfp_pkg::*; #(
  parameter int MAX_PAYLOAD = XCFP_MAX_PAYLOAD,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  parse_dec_t    dec,
  output logic          busy,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [7:0]    out_command,
  output logic [6:0]    out_payload_length,
  output logic          out_has_byte,
  output logic [7:0]    out_payload_data,
  output logic [5:0]    out_byte_position,
  output logic          out_last
);

  logic       burst_r, burst_nxt;
  logic       pend_r, pend_nxt;
  logic [6:0] iss_r, iss_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [7:0] bcmd_r, bcmd_nxt;
  logic [6:0] blen_r, blen_nxt;

  logic       valid_r, valid_nxt;
  status_t    status_r, status_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [6:0] len_r, len_nxt;
  logic       has_r, has_nxt;
  logic [7:0] data_r, data_nxt;
  logic [5:0] bpos_r, bpos_nxt;
  logic       last_r, last_nxt;

  logic       out_free;
  logic       load;
  logic       issue;
  logic       final_beat;

  assign out_free   = !valid_r || out_ready;
  assign load       = pend_r && out_free;
  assign issue      = burst_r && (iss_r < blen_r) && (!pend_r || load);
  assign final_beat = ({1'b0, pos_r} + 7'd1) == blen_r;

  assign busy    = burst_r;
  assign rd_en   = issue;
  assign rd_addr = iss_r[AW-1:0];

  always_comb begin
    burst_nxt = burst_r;
    pend_nxt  = pend_r;
    iss_nxt   = iss_r;
    pos_nxt   = pos_r;
    bcmd_nxt  = bcmd_r;
    blen_nxt  = blen_r;
    if (acc && dec.kind == DEC_BURST) begin
      burst_nxt = 1'b1;
      pend_nxt  = 1'b0;
      iss_nxt   = 7'd0;
      bcmd_nxt  = dec.cmd;
      blen_nxt  = dec.len;
    end else begin
      if (issue) begin
        pend_nxt = 1'b1;
        iss_nxt  = iss_r + 7'd1;
        pos_nxt  = iss_r[5:0];
      end else if (load) begin
        pend_nxt = 1'b0;
      end
      if (load && final_beat) begin
        burst_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    status_nxt = status_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    has_nxt    = has_r;
    data_nxt   = data_r;
    bpos_nxt   = bpos_r;
    last_nxt   = last_r;
    if (acc && dec.kind != DEC_BURST) begin
      valid_nxt  = 1'b1;
      status_nxt = ST_NONE;
      cmd_nxt    = 8'd0;
      len_nxt    = 7'd0;
      has_nxt    = 1'b0;
      data_nxt   = 8'd0;
      bpos_nxt   = 6'd0;
      last_nxt   = 1'b1;
      case (dec.kind)
        DEC_ERROR: status_nxt = ST_ERROR;
        DEC_EMPTY: begin
          status_nxt = ST_FRAME;
          cmd_nxt    = dec.cmd;
        end
        default: ;
      endcase
    end else if (load) begin
      valid_nxt  = 1'b1;
      status_nxt = ST_FRAME;
      cmd_nxt    = bcmd_r;
      len_nxt    = blen_r;
      has_nxt    = 1'b1;
      data_nxt   = rd_data;
      bpos_nxt   = pos_r;
      last_nxt   = final_beat;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r <= 1'b0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      burst_r <= burst_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r    <= iss_nxt;
    pos_r    <= pos_nxt;
    bcmd_r   <= bcmd_nxt;
    blen_r   <= blen_nxt;
    status_r <= status_nxt;
    cmd_r    <= cmd_nxt;
    len_r    <= len_nxt;
    has_r    <= has_nxt;
    data_r   <= data_nxt;
    bpos_r   <= bpos_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_command        = cmd_r;
  assign out_payload_length = len_r;
  assign out_has_byte       = has_r;
  assign out_payload_data   = data_r;
  assign out_byte_position  = bpos_r;
  assign out_last           = last_r;

endmodule

[rtl/xor_checked_frame_parser.sv]
// Top level of the byte-serial frame parser with XOR checksum.
// Takes one received byte per beat on the in_ channel and parses frames laid
// out as magic, command, length, payload and checksum. A byte equal to the
// magic register restarts the parse wherever it appears. Every accepted byte
// gives at least one beat on the out_ channel: a status 0 beat while nothing
// completes, a status 2 beat for a length above MAX_PAYLOAD or a checksum
// mismatch, and for a good frame either one status 1 beat (empty payload) or
// one beat per payload byte, the final one flagged by out_last. The checksum
// is accumulated as bytes arrive; payload bytes go to a MAX_PAYLOAD x 8 RAM
// and are streamed back from its single read port after the checksum beat.
// Rate: one input byte per cycle while out_ready is high; the checksum byte
// of a good frame holds in_ready low while the RAM read port delivers the
// payload, one byte per cycle while out_ready is high. An out_ready stall
// lengthens the burst. The result register parts the two sides, so a byte
// is accepted in the cycle its predecessor's result leaves.
// cfg_ (magic byte, reset 0xAA) is always ready; write it only while idle.
module xor_checked_frame_parser import xcfp_pkg::*; #(
  parameter int MAX_PAYLOAD = XCFP_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_command,
  output logic [6:0] out_payload_length,
  output logic       out_has_byte,
  output logic [7:0] out_payload_data,
  output logic [5:0] out_byte_position,
  output logic       out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          [7:0] magic_r;
  logic                in_acc;
  logic                busy;
  parse_dec_t          dec;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;

  // Magic register: hold until a config beat lands.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= XCFP_MAGIC_RESET;
    end else if (cfg_valid) begin
      magic_r <= cfg_data;
    end
  end

  // Take a byte only when no payload burst is running and the result
  // register is empty or draining this cycle. Holding in_ready low during a
  // burst also keeps RAM writes away from the entries being read back.
  assign in_ready = !busy && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  xcfp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .rx_byte (in_rx_byte),
    .magic   (magic_r),
    .dec     (dec),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Payload store: written in the data phase, read back during delivery.
  xcfp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xcfp_emitter #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_emitter (
    .clk                (clk),
    .rst_n              (rst_n),
    .acc                (in_acc),
    .dec                (dec),
    .busy               (busy),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_command        (out_command),
    .out_payload_length (out_payload_length),
    .out_has_byte       (out_has_byte),
    .out_payload_data   (out_payload_data),
    .out_byte_position  (out_byte_position),
    .out_last           (out_last)
  );

endmodule

[rtl/xcfp_checker.sv]
// Port-level checker for the frame parser, bound to the top level.
`include "xor_checked_frame_parser_macros.svh"

module xcfp_port_checker import xcfp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_command,
  input logic [6:0] out_payload_length,
  input logic       out_has_byte,
  input logic [7:0] out_payload_data,
  input logic [5:0] out_byte_position,
  input logic       out_last
);

  `XCFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload_data) && $stable(out_last))
  `XCFP_ASSERT_SAME(a_err_clean, out_valid && out_status == ST_ERROR, out_last && !out_has_byte && out_command == 8'd0 && out_payload_length == 7'd0)
  `XCFP_ASSERT_SAME(a_no_byte_last, out_valid && !out_has_byte, out_last && out_payload_data == 8'd0 && out_byte_position == 6'd0)
  `XCFP_ASSERT_SAME(a_burst_blocks, out_valid && !out_last, !in_ready && out_status == ST_FRAME && out_has_byte)

endmodule

bind xor_checked_frame_parser xcfp_port_checker u_xcfp_port_checker (.*);
